/* hdl/pwhl_pkg.sv */
// ----------------------------------------------------------------------------
// pwhl_pkg
// Shared constants and controller/datapath interface types for the
// half-level pulse width block.
// ----------------------------------------------------------------------------
package pwhl_pkg;

	localparam int MAX_SAMPLES = 1024;
	localparam int ADDR_W      = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int SAMPLE_W    = 16;
	localparam int PERIOD_W    = 16;
	localparam int DUR_W       = 26;
	localparam int PROD_W      = CNT_W + PERIOD_W;

	// controller to datapath
	typedef struct packed {
		logic take;     // input beat accepted this cycle
		logic scan_rd;  // read one stored sample
		logic mul;      // form count times period
		logic emit;     // load result register and clear record
	} pwhl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last; // current read address is the last stored entry
		logic out_free;  // result register can take a new result
	} pwhl_sts_t;

endpackage

/* hdl/pwhl_ctrl.sv */
// ----------------------------------------------------------------------------
// pwhl_ctrl
// Sequencer: load phase, counting pass over the store, multiply, hand-off
// of the result into the output register.
// ----------------------------------------------------------------------------
module pwhl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                last_sample,
	input  pwhl_pkg::pwhl_sts_t sts,
	output pwhl_pkg::pwhl_cmd_t cmd,
	output logic                in_stall
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_MUL,
		ST_OUT
	} state_t;

	state_t state_q;

	always_comb begin
		cmd         = '0;
		cmd.take    = (state_q == ST_LOAD) && in_valid;
		cmd.scan_rd = (state_q == ST_SCAN);
		cmd.mul     = (state_q == ST_MUL);
		cmd.emit    = (state_q == ST_OUT) && sts.out_free;
	end

	assign in_stall = (state_q != ST_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_valid && last_sample) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.scan_last) state_q <= ST_DRAIN;
				end
				// last read data is compared and counted here
				ST_DRAIN: state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_OUT;
				ST_OUT: begin
					if (sts.out_free) state_q <= ST_LOAD;
				end
				default:  state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

/* hdl/pwhl_dp.sv */
// ----------------------------------------------------------------------------
// pwhl_dp
// Datapath: sample store, running min/max, counting pass with registered
// read, period multiplier and the output register.
// ----------------------------------------------------------------------------
module pwhl_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  pwhl_pkg::pwhl_cmd_t                    cmd,
	output pwhl_pkg::pwhl_sts_t                    sts,
	input  logic                                   sample_period_we,
	input  logic        [pwhl_pkg::PERIOD_W-1:0]   sample_period,
	input  logic signed [pwhl_pkg::SAMPLE_W-1:0]   sample,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic        [pwhl_pkg::DUR_W-1:0]      duration,
	output logic        [pwhl_pkg::CNT_W-1:0]      above_count,
	output logic signed [pwhl_pkg::SAMPLE_W-1:0]   peak_max,
	output logic signed [pwhl_pkg::SAMPLE_W-1:0]   peak_min,
	output logic                                   overflowed
);

	logic signed [pwhl_pkg::SAMPLE_W-1:0] mem [pwhl_pkg::MAX_SAMPLES];

	logic        [pwhl_pkg::PERIOD_W-1:0] period_q;
	logic signed [pwhl_pkg::SAMPLE_W-1:0] max_q;
	logic signed [pwhl_pkg::SAMPLE_W-1:0] min_q;
	logic        [pwhl_pkg::CNT_W-1:0]    count_q;
	logic                                 drop_q;
	logic        [pwhl_pkg::CNT_W-1:0]    rd_idx_q;
	logic                                 rd_valid_s1;
	logic signed [pwhl_pkg::SAMPLE_W-1:0] rd_data_s1;
	logic        [pwhl_pkg::CNT_W-1:0]    above_q;
	logic        [pwhl_pkg::PROD_W-1:0]   prod_q;
	logic                                 out_valid_q;

	logic                                 full;
	logic signed [pwhl_pkg::SAMPLE_W:0]   mid_sum;
	logic signed [pwhl_pkg::SAMPLE_W:0]   twice;

	assign full    = (count_q == pwhl_pkg::CNT_W'(pwhl_pkg::MAX_SAMPLES));
	// 2*s > max+min, exact in one extra bit
	assign mid_sum = {max_q[pwhl_pkg::SAMPLE_W-1], max_q}
	               + {min_q[pwhl_pkg::SAMPLE_W-1], min_q};
	assign twice   = {rd_data_s1, 1'b0};

	assign sts.scan_last = (rd_idx_q == pwhl_pkg::CNT_W'(count_q - 1'b1));
	assign sts.out_free  = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;

	// sample store
	always_ff @(posedge clk) begin
		if (cmd.take && !full) begin
			mem[count_q[pwhl_pkg::ADDR_W-1:0]] <= sample;
		end
		rd_data_s1 <= mem[rd_idx_q[pwhl_pkg::ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= pwhl_pkg::PERIOD_W'(1);
			max_q       <= '0;
			min_q       <= '0;
			count_q     <= '0;
			drop_q      <= 1'b0;
			rd_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
			above_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (sample_period_we) period_q <= sample_period;

			if (cmd.take) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
					if (count_q == '0) begin
						max_q <= sample;
						min_q <= sample;
					end else begin
						if (sample > max_q) max_q <= sample;
						if (sample < min_q) min_q <= sample;
					end
				end
			end

			rd_valid_s1 <= cmd.scan_rd;
			if (cmd.scan_rd) rd_idx_q <= rd_idx_q + 1'b1;
			if (rd_valid_s1 && (twice > mid_sum)) above_q <= above_q + 1'b1;

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				max_q       <= '0;
				min_q       <= '0;
				count_q     <= '0;
				drop_q      <= 1'b0;
				rd_idx_q    <= '0;
				above_q     <= '0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.mul) prod_q <= above_q * period_q;
		if (cmd.emit) begin
			duration    <= prod_q[pwhl_pkg::DUR_W-1:0];
			above_count <= above_q;
			peak_max    <= max_q;
			peak_min    <= min_q;
			overflowed  <= drop_q;
		end
	end

endmodule

/* hdl/pulse_width_half_level.sv */
// ----------------------------------------------------------------------------
// pulse_width_half_level
// Pulse width at half amplitude over a record of signed samples.
//
// Usage:
//   input beats carry one sample each; last_sample marks the end of a record.
//   A beat moves when in_valid is high and in_stall is low.
//   Samples load one per cycle while the block is in its load phase.
//   After the last beat the block stalls the input and counts the stored
//   samples with 2*sample > max+min, one store read per cycle.
//   One result beat per record: duration = count * sample_period, the count,
//   max, min and an overflow flag for samples dropped beyond 1024.
//   After the last sample, out_valid follows the reads of the N stored
//   samples from the single store port, a compare drain state, a multiply
//   state and a hand-off state.
//   A new record loads only after the previous result is handed off.
//   The result sits in an output register; the next record loads while it
//   waits, and the hand-off of that record waits for out_stall to drop.
//   The user writes sample_period through sample_period_we while idle only; not enforced.
//   Reset clears the record state and sets sample_period to 1; the store
//   itself is not cleared (entries are read only after being written).
// ----------------------------------------------------------------------------
module pulse_width_half_level (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_period_we,
	input  logic        [pwhl_pkg::PERIOD_W-1:0] sample_period,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [pwhl_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 last_sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic        [pwhl_pkg::DUR_W-1:0]    duration,
	output logic        [pwhl_pkg::CNT_W-1:0]    above_count,
	output logic signed [pwhl_pkg::SAMPLE_W-1:0] peak_max,
	output logic signed [pwhl_pkg::SAMPLE_W-1:0] peak_min,
	output logic                                 overflowed
);

	pwhl_pkg::pwhl_cmd_t cmd;
	pwhl_pkg::pwhl_sts_t sts;

	pwhl_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_sample (last_sample),
		.sts         (sts),
		.cmd         (cmd),
		.in_stall    (in_stall)
	);

	pwhl_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.sample_period_we (sample_period_we),
		.sample_period    (sample_period),
		.sample           (sample),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.duration         (duration),
		.above_count      (above_count),
		.peak_max         (peak_max),
		.peak_min         (peak_min),
		.overflowed       (overflowed)
	);

	// end of record starts the counting pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last_sample) |=> in_stall)
		else $error("input not stalled after end of record");

	// a fresh result has ordered peaks
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (peak_min <= peak_max))
		else $error("peak_min above peak_max");

	// count never exceeds store capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (above_count <= pwhl_pkg::CNT_W'(pwhl_pkg::MAX_SAMPLES)))
		else $error("above_count beyond capacity");

endmodule
